// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/jtbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jtbt_pkg
// Types and codes of the journal transaction block tracker.
// ----------------------------------------------------------------------------
package jtbt_pkg;

	localparam int BLK_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 5;
	localparam int COUNT_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int LRB_W      = 11;
	localparam int RSV_W      = 6;

	localparam logic [COUNT_W-1:0] OPS_MAX = 6'd63;

	localparam logic [1:0] REQ_BEGIN = 2'd0;
	localparam logic [1:0] REQ_END   = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_DRAIN = 2'd3;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_WAIT      = 3'd1;
	localparam logic [STATUS_W-1:0] STS_COMMIT    = 3'd2;
	localparam logic [STATUS_W-1:0] STS_TOO_BIG   = 3'd3;
	localparam logic [STATUS_W-1:0] STS_OUTSIDE   = 3'd4;
	localparam logic [STATUS_W-1:0] STS_BAD_END   = 3'd5;
	localparam logic [STATUS_W-1:0] STS_NO_COMMIT = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_LOG_REGION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_OP     = 2'd1;

	localparam logic [LRB_W-1:0] LRB_RESET = 11'd30;
	localparam logic [RSV_W-1:0] RSV_RESET = 6'd10;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [BLK_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_index;
		logic                absorbed;
		logic [BLK_W-1:0]    block_out;
		logic                last_of_run;
		logic [COUNT_W-1:0]  entry_count;
		logic [COUNT_W-1:0]  active_ops;
	} result_t;

	typedef struct packed {
		logic [LRB_W-1:0] log_region_blocks;
		logic [RSV_W-1:0] per_op_reserve;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} seq_state_t;

endpackage

// ===== src/jtbt_table.sv =====
// ----------------------------------------------------------------------------
// jtbt_table
// Logged block table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module jtbt_table import jtbt_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  logic [BLK_W-1:0] wdata,
	input  logic             re,
	input  logic [IW-1:0]    raddr,
	output logic [BLK_W-1:0] rdata
);

	logic [BLK_W-1:0] mem_q [DEPTH];
	logic [BLK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/jtbt_seq.sv =====
// ----------------------------------------------------------------------------
// jtbt_seq
// Request sequencer: admission, end, absorbing search and drain over the table.
// ----------------------------------------------------------------------------
module jtbt_seq import jtbt_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	parameter int IW          = 5,
	parameter int CW          = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	input  cfg_t             cfg,
	output logic             done,
	output result_t          result,
	output logic             mem_we,
	output logic [IW-1:0]    mem_waddr,
	output logic [BLK_W-1:0] mem_wdata,
	output logic             mem_re,
	output logic [IW-1:0]    mem_raddr,
	input  logic [BLK_W-1:0] mem_rdata
);

	localparam int NEED_W = 14;
	localparam logic [NEED_W-1:0] NEED_LIMIT = NEED_W'(TABLE_DEPTH - 2);
	localparam logic [CW-1:0]     DEPTH_C    = CW'(TABLE_DEPTH);

	seq_state_t state_q, state_d;

	logic [CW-1:0]      entries_q, entries_d;
	logic [COUNT_W-1:0] ops_q, ops_d;
	logic               pending_q, pending_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic               pend_q, pend_d;
	logic [CW-1:0]      pend_idx_q, pend_idx_d;
	logic [CW-1:0]      n_q, n_d;
	logic [BLK_W-1:0]   blk_q, blk_d;
	logic               done_q, done_d;
	result_t            res_q, res_d;

	logic               accept;
	logic [6:0]         ops_inc;
	logic [12:0]        reserve_all;
	logic [NEED_W-1:0]  need;
	logic               wait_c;
	logic [LRB_W-1:0]   limit_raw;
	logic               too_big;
	logic               outside;
	logic               go_scan;
	logic               go_drain;
	logic               scan_issue;
	logic               hit;
	logic               tail;
	logic               drain_issue;
	logic               drain_last;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign ops_inc     = {1'b0, ops_q} + 7'd1;
	assign reserve_all = ops_inc * cfg.per_op_reserve;
	assign need        = NEED_W'(entries_q) + NEED_W'(reserve_all);
	assign wait_c      = pending_q || (ops_q == OPS_MAX) || (need > NEED_LIMIT);

	assign limit_raw = (cfg.log_region_blocks >= 11'd2) ? cfg.log_region_blocks - 11'd2 : '0;
	assign too_big   = (12'(entries_q) >= 12'(limit_raw)) || (entries_q >= DEPTH_C);
	assign outside   = (ops_q == '0) || pending_q;

	assign go_scan  = (req.req_type == REQ_WRITE) && !too_big && !outside && (entries_q != '0);
	assign go_drain = (req.req_type == REQ_DRAIN) && pending_q && (entries_q != '0);

	assign scan_issue  = (idx_q < entries_q);
	assign hit         = pend_q && (mem_rdata == blk_q);
	assign tail        = pend_q && !hit && (pend_idx_q == entries_q - CW'(1));
	assign drain_issue = (idx_q < n_q);
	assign drain_last  = (pend_idx_q == n_q - CW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && go_scan) begin
					state_d = ST_SCAN;
				end else if (accept && go_drain) begin
					state_d = ST_DRAIN;
				end
			end
			ST_SCAN: begin
				if (hit || tail) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (pend_q && drain_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		entries_d  = entries_q;
		ops_d      = ops_q;
		pending_d  = pending_q;
		idx_d      = idx_q;
		pend_d     = 1'b0;
		pend_idx_d = pend_idx_q;
		n_d        = n_q;
		blk_d      = blk_q;
		done_d     = 1'b0;
		res_d      = '0;
		mem_we     = 1'b0;
		mem_waddr  = entries_q[IW-1:0];
		mem_wdata  = blk_q;
		mem_re     = 1'b0;
		mem_raddr  = idx_q[IW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_d.last_of_run = 1'b1;
					unique case (req.req_type)
						REQ_BEGIN: begin
							done_d = 1'b1;
							if (wait_c) begin
								res_d.status = STS_WAIT;
							end else begin
								ops_d        = ops_q + COUNT_W'(1);
								res_d.status = STS_OK;
							end
						end
						REQ_END: begin
							done_d = 1'b1;
							if (pending_q || (ops_q == '0)) begin
								res_d.status = STS_BAD_END;
							end else begin
								ops_d = ops_q - COUNT_W'(1);
								if (ops_q == COUNT_W'(1)) begin
									pending_d    = 1'b1;
									res_d.status = STS_COMMIT;
								end else begin
									res_d.status = STS_OK;
								end
							end
						end
						REQ_WRITE: begin
							if (too_big) begin
								done_d       = 1'b1;
								res_d.status = STS_TOO_BIG;
							end else if (outside) begin
								done_d       = 1'b1;
								res_d.status = STS_OUTSIDE;
							end else if (entries_q == '0) begin
								mem_we       = 1'b1;
								mem_waddr    = '0;
								mem_wdata    = req.block_number;
								entries_d    = CW'(1);
								done_d       = 1'b1;
								res_d.status = STS_OK;
							end else begin
								blk_d = req.block_number;
								idx_d = '0;
							end
						end
						REQ_DRAIN: begin
							if (!pending_q) begin
								done_d       = 1'b1;
								res_d.status = STS_NO_COMMIT;
							end else begin
								n_d       = entries_q;
								entries_d = '0;
								ops_d     = '0;
								pending_d = 1'b0;
								idx_d     = '0;
								if (entries_q == '0) begin
									done_d       = 1'b1;
									res_d.status = STS_OK;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				mem_re     = scan_issue;
				pend_d     = scan_issue;
				pend_idx_d = idx_q;
				idx_d      = idx_q + CW'(scan_issue);
				if (hit) begin
					done_d            = 1'b1;
					res_d.status      = STS_OK;
					res_d.slot_index  = SLOT_W'(pend_idx_q);
					res_d.absorbed    = 1'b1;
					res_d.last_of_run = 1'b1;
				end else if (tail) begin
					mem_we            = 1'b1;
					entries_d         = entries_q + CW'(1);
					done_d            = 1'b1;
					res_d.status      = STS_OK;
					res_d.slot_index  = SLOT_W'(entries_q);
					res_d.last_of_run = 1'b1;
				end
			end
			ST_DRAIN: begin
				mem_re     = drain_issue;
				pend_d     = drain_issue;
				pend_idx_d = idx_q;
				idx_d      = idx_q + CW'(drain_issue);
				if (pend_q) begin
					done_d            = 1'b1;
					res_d.status      = STS_OK;
					res_d.slot_index  = SLOT_W'(pend_idx_q);
					res_d.block_out   = mem_rdata;
					res_d.last_of_run = drain_last;
				end
			end
			default: ;
		endcase
		res_d.entry_count = COUNT_W'(entries_d);
		res_d.active_ops  = ops_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			entries_q  <= '0;
			ops_q      <= '0;
			pending_q  <= 1'b0;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			n_q        <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			entries_q  <= entries_d;
			ops_q      <= ops_d;
			pending_q  <= pending_d;
			idx_q      <= idx_d;
			pend_q     <= pend_d;
			pend_idx_q <= pend_idx_d;
			n_q        <= n_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		blk_q <= blk_d;
		res_q <= res_d;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== src/journal_transaction_block_tracker.sv =====
// ----------------------------------------------------------------------------
// journal_transaction_block_tracker
// Write-ahead journal transaction tracker with block absorption.
// ----------------------------------------------------------------------------
//  channel   signals                              transfer
//  request   start, busy, req                     start && !busy
//  result    done, result                         one cycle per done pulse
//  config    cfg_valid, cfg_ready, cfg_index/data cfg_valid && cfg_ready
//
//  Begin, end, rejected writes, writes into an empty table, rejected drains
//  and drains of no entries: result in the cycle after the request. A write
//  that searches walks the logged slots through the single table read port,
//  one compare per slot. A drain of n entries emits one result per cycle.
//  Reset clears counts and the commit flag; table contents are not cleared.
//  busy stays high for the whole search or drain; results cannot be stalled.
// ----------------------------------------------------------------------------
module journal_transaction_block_tracker import jtbt_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	cfg_t             cfg_q;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [BLK_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IW-1:0]    mem_raddr;
	logic [BLK_W-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.log_region_blocks <= LRB_RESET;
			cfg_q.per_op_reserve    <= RSV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_LOG_REGION) begin
				cfg_q.log_region_blocks <= cfg_data[LRB_W-1:0];
			end else if (cfg_index == CFG_PER_OP) begin
				cfg_q.per_op_reserve <= cfg_data[RSV_W-1:0];
			end
		end
	end

	jtbt_seq #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IW(IW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg(cfg_q),
		.done(done),
		.result(result),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	jtbt_table #(
		.DEPTH(TABLE_DEPTH),
		.IW(IW)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ===== src/jtbt_checker.sv =====
// ----------------------------------------------------------------------------
// jtbt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jtbt_checker import jtbt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input req_t    req,
	input logic    done,
	input result_t result
);

	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> (!done && !busy), "done or busy during reset")
	`ASSERT_CLK(a_short_req, clk, arst_n, (start && !busy && (req.req_type == REQ_BEGIN || req.req_type == REQ_END)) |=> (done && result.last_of_run), "begin/end result missing")
	`ASSERT_CLK(a_err_single, clk, arst_n, (done && (result.status != STS_OK)) |-> result.last_of_run, "error result not last")
	`ASSERT_CLK(a_drain_burst, clk, arst_n, (done && !result.last_of_run) |=> done, "gap inside drain burst")
	`ASSERT_CLK(a_accept_moves, clk, arst_n, (start && !busy) |=> (busy || done), "accepted transaction dropped")

endmodule

bind journal_transaction_block_tracker jtbt_checker u_jtbt_checker (.*);

// ===== tb/sv/journal_transaction_block_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// journal_transaction_block_tracker_test
// Self-checking bench for the journal transaction block tracker. A queue-fed
// driver issues begin/end/write/drain requests with random gaps, a model of
// the transaction table predicts every result, and a monitor compares each
// done pulse field by field. Several register settings are exercised,
// including the table and reserve extremes.
// ----------------------------------------------------------------------------
module journal_transaction_block_tracker_test;
	import jtbt_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int WATCHDOG    = 2000;
	localparam int SETTLE      = TABLE_DEPTH + 8;

	typedef struct {
		req_t        r;
		int unsigned gap;
	} pending_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	req_t                  req       = '0;
	logic                  done;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	journal_transaction_block_tracker #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// journal model state
	logic [BLK_W-1:0] jr_blocks [TABLE_DEPTH];
	int unsigned      jr_entries = 0;
	int unsigned      jr_ops     = 0;
	bit               jr_commit  = 1'b0;
	int unsigned      jr_lrb     = LRB_RESET;
	int unsigned      jr_rsv     = RSV_RESET;

	result_t     journal_expect_q[$];
	pending_t    pending[$];
	pending_t    staged;
	bit          staged_ok   = 1'b0;
	bit          no_idle     = 1'b0;
	int unsigned errors      = 0;
	int unsigned items_sent  = 0;
	int unsigned results_got = 0;
	int unsigned reg_writes  = 0;
	int unsigned settings    = 0;
	int unsigned idle_cycles = 0;
	logic [BLK_W-1:0] blk_pool [6];

	function automatic void push_outcome(logic [STATUS_W-1:0] sts, int unsigned slot,
			bit absorbed, logic [BLK_W-1:0] blk, bit last);
		result_t e;
		e.status      = sts;
		e.slot_index  = slot[SLOT_W-1:0];
		e.absorbed    = absorbed;
		e.block_out   = blk;
		e.last_of_run = last;
		e.entry_count = jr_entries[COUNT_W-1:0];
		e.active_ops  = jr_ops[COUNT_W-1:0];
		journal_expect_q.push_back(e);
	endfunction

	function automatic void predict_journal(req_t r);
		int unsigned need;
		int unsigned limit;
		int unsigned i;
		int unsigned n;
		items_sent++;
		case (r.req_type)
			REQ_BEGIN: begin
				need = jr_entries + (jr_ops + 1) * jr_rsv;
				if (jr_commit || jr_ops >= OPS_MAX || need > TABLE_DEPTH - 2) begin
					push_outcome(STS_WAIT, 0, 0, '0, 1);
				end else begin
					jr_ops++;
					push_outcome(STS_OK, 0, 0, '0, 1);
				end
			end
			REQ_END: begin
				if (jr_commit || jr_ops == 0) begin
					push_outcome(STS_BAD_END, 0, 0, '0, 1);
				end else begin
					jr_ops--;
					if (jr_ops == 0) begin
						jr_commit = 1'b1;
						push_outcome(STS_COMMIT, 0, 0, '0, 1);
					end else begin
						push_outcome(STS_OK, 0, 0, '0, 1);
					end
				end
			end
			REQ_WRITE: begin
				limit = (jr_lrb >= 2) ? jr_lrb - 2 : 0;
				if (limit > TABLE_DEPTH)
					limit = TABLE_DEPTH;
				if (jr_entries >= limit) begin
					push_outcome(STS_TOO_BIG, 0, 0, '0, 1);
				end else if (jr_ops == 0 || jr_commit) begin
					push_outcome(STS_OUTSIDE, 0, 0, '0, 1);
				end else begin
					i = 0;
					while (i < jr_entries && jr_blocks[i] != r.block_number)
						i++;
					jr_blocks[i] = r.block_number;
					if (i == jr_entries) begin
						jr_entries++;
						push_outcome(STS_OK, i, 0, '0, 1);
					end else begin
						push_outcome(STS_OK, i, 1, '0, 1);
					end
				end
			end
			default: begin
				if (!jr_commit) begin
					push_outcome(STS_NO_COMMIT, 0, 0, '0, 1);
				end else begin
					n = jr_entries;
					jr_entries = 0;
					jr_ops     = 0;
					jr_commit  = 1'b0;
					if (n == 0)
						push_outcome(STS_OK, 0, 0, '0, 1);
					for (i = 0; i < n; i++)
						push_outcome(STS_OK, i, 0, jr_blocks[i], i + 1 == n);
				end
			end
		endcase
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy)
				predict_journal(req);
			if (!(start && busy)) begin
				if (!staged_ok && pending.size() != 0) begin
					staged    = pending.pop_front();
					staged_ok = 1'b1;
				end
				if (staged_ok && staged.gap == 0) begin
					start     <= 1'b1;
					req       <= staged.r;
					staged_ok = 1'b0;
				end else begin
					start <= 1'b0;
					if (staged_ok)
						staged.gap--;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// result monitor
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			results_got++;
			if (journal_expect_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0h", $time, result);
				errors++;
			end else begin
				e = journal_expect_q.pop_front();
				check_field("status", e.status, result.status);
				check_field("slot_index", e.slot_index, result.slot_index);
				check_field("absorbed", e.absorbed, result.absorbed);
				check_field("block_out", e.block_out, result.block_out);
				check_field("last_of_run", e.last_of_run, result.last_of_run);
				check_field("entry_count", e.entry_count, result.entry_count);
				check_field("active_ops", e.active_ops, result.active_ops);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time,
					journal_expect_q.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [BLK_W-1:0] pick_block();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return blk_pool[$urandom_range(0, 5)];
		if (r < 50)
			return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom;
	endfunction

	task automatic queue_req(input logic [1:0] kind, input logic [BLK_W-1:0] blk);
		pending_t p;
		p.r.req_type     = kind;
		p.r.block_number = blk;
		p.gap            = pick_gap();
		pending.push_back(p);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == CFG_LOG_REGION)
			jr_lrb = data;
		else if (idx == CFG_PER_OP)
			jr_rsv = data[RSV_W-1:0];
	endtask

	task automatic set_config(input int unsigned lrb, input int unsigned rsv);
		logic [CFG_DATA_W-1:0] rsv_word;
		rsv_word = $urandom;
		rsv_word[RSV_W-1:0] = rsv[RSV_W-1:0];
		write_reg(CFG_LOG_REGION, lrb[CFG_DATA_W-1:0]);
		write_reg(CFG_PER_OP, rsv_word);
		settings++;
	endtask

	task automatic wait_quiet();
		while (pending.size() != 0 || staged_ok || start || busy || journal_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned target);
		int unsigned queued;
		int unsigned k;
		int unsigned n;
		int unsigned j;
		queued = 0;
		while (queued < target) begin
			if ($urandom_range(0, 99) < 80) begin
				for (j = 0; j < 6; j++)
					blk_pool[j] = $urandom;
				k = $urandom_range(1, 3);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(0, 8);
				for (j = 0; j < k; j++)
					queue_req(REQ_BEGIN, $urandom);
				for (j = 0; j < n; j++)
					queue_req(REQ_WRITE, pick_block());
				for (j = 0; j < k; j++)
					queue_req(REQ_END, $urandom);
				queue_req(REQ_DRAIN, $urandom);
				queued += 2 * k + n + 1;
			end else begin
				n = $urandom_range(1, 4);
				for (j = 0; j < n; j++)
					queue_req(2'($urandom_range(0, 3)), pick_block());
				queued += n;
			end
		end
	endtask

	initial begin
		int unsigned p;
		for (int i = 0; i < TABLE_DEPTH; i++)
			jr_blocks[i] = '0;
		for (int i = 0; i < 6; i++)
			blk_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// error paths, admission limit, absorption, commit and drain
		set_config(LRB_RESET, RSV_RESET);
		queue_req(REQ_DRAIN, 32'h0);
		queue_req(REQ_END, 32'hFFFF_FFFF);
		queue_req(REQ_WRITE, 32'h1234_5678);
		queue_req(REQ_BEGIN, 32'h0);
		queue_req(REQ_BEGIN, 32'h0);
		queue_req(REQ_BEGIN, 32'h0);
		queue_req(REQ_BEGIN, 32'h0);
		queue_req(REQ_WRITE, 32'h0);
		queue_req(REQ_WRITE, 32'hFFFF_FFFF);
		queue_req(REQ_WRITE, 32'h0);
		queue_req(REQ_WRITE, 32'hA5A5_5A5A);
		queue_req(REQ_END, 32'h0);
		queue_req(REQ_END, 32'h0);
		queue_req(REQ_END, 32'h0);
		queue_req(REQ_BEGIN, 32'h0);
		queue_req(REQ_WRITE, 32'h5A5A_A5A5);
		queue_req(REQ_END, 32'h0);
		queue_req(REQ_DRAIN, 32'h0);
		queue_req(REQ_DRAIN, 32'h0);
		queue_req(REQ_BEGIN, 32'h0);
		queue_req(REQ_END, 32'h0);
		queue_req(REQ_DRAIN, 32'h0);
		wait_quiet();

		// one-entry log: second write is too big even though it would absorb
		set_config(3, 1);
		queue_req(REQ_BEGIN, 32'h0);
		queue_req(REQ_WRITE, 32'h0000_0042);
		queue_req(REQ_WRITE, 32'h0000_0042);
		queue_req(REQ_END, 32'h0);
		queue_req(REQ_DRAIN, 32'h0);
		wait_quiet();

		for (p = 0; p < 8; p++) begin
			no_idle = (p == 5);
			case (p)
				0: set_config(1024, 1);
				1: set_config(3, 32);
				2: set_config(34, 3);
				3: set_config(LRB_RESET, RSV_RESET);
				5: set_config(1024, 1);
				7: set_config(8, 1);
				default: set_config($urandom_range(3, 1024), $urandom_range(1, 32));
			endcase
			random_phase((p == 1) ? 30 : 65);
			wait_quiet();
		end

		$display("Covered %0d requests and %0d results under %0d register settings",
			items_sent, results_got, settings);
		$display("(%0d register writes, %0d mismatches)", reg_writes, errors);
		if (errors == 0 && journal_expect_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
